// ----- design/indexed_min_heap_queue_defines.svh -----
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_defines.svh
// Assertion macros for the indexed min-heap queue.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define IMHQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IMHQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

// ----- design/imhq_pkg.sv -----
// ----------------------------------------------------------------------------
// imhq_pkg
// Types, codes and defaults for the indexed min-heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

package imhq_pkg;

	localparam int NODE_COUNT_DEF = 4096;
	localparam int KEY_BITS_DEF   = 32;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_EMPTY      = 3'd1,
		STAT_NOT_PRESENT = 3'd2,
		STAT_PRESENT    = 3'd3,
		STAT_FULL       = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK1,
		ST_LOOK2,
		ST_LAST0,
		ST_LAST1,
		ST_POP0,
		ST_POP1,
		ST_POP2,
		ST_UP0,
		ST_UP1,
		ST_UP2,
		ST_DN0,
		ST_DN1,
		ST_DN2,
		ST_DN3,
		ST_DN4,
		ST_FIN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- design/indexed_min_heap_queue.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap of node numbers keyed by (primary, secondary, node).
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall   | operation, node, primary_key,
//          |           |                      | secondary_key
//  out     | output    | out_valid / out_stall | status, popped_node,
//          |           |                      | popped_primary, popped_secondary,
//          |           |                      | entries
//
//  One item at a time. Lookup reads the position map, then the heap slot. Each
//  sift-up level reads the parent slot and its key, each sift-down level both
//  children and their keys (one read port per memory); a finish state writes back.
//  After reset a clearing pass sweeps every entry of the position map;
//  input is stalled meanwhile. A waiting result stalls only the next finish.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_min_heap_queue_defines.svh"

module indexed_min_heap_queue #(
	parameter int NODE_COUNT = imhq_pkg::NODE_COUNT_DEF,
	parameter int KEY_BITS   = imhq_pkg::KEY_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [11:0] node,
	input  wire logic [31:0] primary_key,
	input  wire logic [31:0] secondary_key,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [11:0]      popped_node,
	output logic [31:0]      popped_primary,
	output logic [31:0]      popped_secondary,
	output logic [12:0]      entries
);
	import imhq_pkg::*;

	localparam int NW = $clog2(NODE_COUNT);
	localparam int CW = $clog2(NODE_COUNT + 1);
	localparam int LW = CW + 1;
	localparam int KB = KEY_BITS;

	// storage
	logic [NW-1:0]     hs_mem [NODE_COUNT];
	logic [NW-1:0]     sn_mem [NODE_COUNT];
	logic [2*KB-1:0]   kn_mem [NODE_COUNT];

	logic [NW-1:0]     hs_raddr, hs_waddr, hs_wdata, hs_rd_q;
	logic              hs_we;
	logic [NW-1:0]     sn_raddr, sn_waddr, sn_wdata, sn_rd_q;
	logic              sn_we;
	logic [NW-1:0]     kn_raddr;
	logic [2*KB-1:0]   kn_rd_q;
	logic              kn_we;

	state_t            state_q, state_n;
	logic [CW-1:0]     count_q;
	logic [NW-1:0]     clr_q;
	logic              out_valid_q;

	op_t               op_q;
	logic [NW-1:0]     node_q;
	logic [KB-1:0]     pk_in_q, sk_in_q;
	logic [NW-1:0]     pos_q;
	logic              in_range_q;
	logic              first_q;
	logic [NW-1:0]     cur_node_q, oth_node_q, l_node_q, r_node_q, best_node_q, top_q;
	logic [KB-1:0]     cur_pk_q, cur_sk_q, l_pk_q, l_sk_q, best_pk_q, best_sk_q;
	logic [NW-1:0]     best_pos_q;
	logic [KB-1:0]     pop_pk_q, pop_sk_q;
	logic              pop_hit_q;
	status_t           stat_q;

	logic [2:0]        status_q;
	logic [11:0]       popped_node_q;
	logic [31:0]       popped_primary_q, popped_secondary_q;
	logic [12:0]       entries_q;

	// input decode
	logic [NW+11:0]    node_ext;
	logic [NW-1:0]     in_idx;
	logic              in_ok;
	logic [KB+31:0]    pk_ext, sk_ext;
	logic              accept, out_load;

	assign node_ext = {{NW{1'b0}}, node};
	assign in_idx   = node_ext[NW-1:0];
	assign in_ok    = {20'd0, node} < 32'(NODE_COUNT);
	assign pk_ext   = {{KB{1'b0}}, primary_key};
	assign sk_ext   = {{KB{1'b0}}, secondary_key};
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// position arithmetic
	logic [CW-1:0]     cm1;
	logic [NW-1:0]     last_pos, parent;
	logic [LW-1:0]     left_w, right_w;
	logic              left_ok, right_ok, present, full;
	logic [KB-1:0]     kn_pk, kn_sk;

	assign cm1      = count_q - 1'b1;
	assign last_pos = cm1[NW-1:0];
	assign parent   = (pos_q - 1'b1) >> 1;
	assign left_w   = LW'({pos_q, 1'b1});
	assign right_w  = left_w + 1'b1;
	assign left_ok  = left_w < LW'(count_q);
	assign right_ok = right_w < LW'(count_q);
	assign present  = in_range_q && (hs_rd_q == node_q);
	assign full     = count_q >= CW'(NODE_COUNT);
	assign kn_pk    = kn_rd_q[2*KB-1:KB];
	assign kn_sk    = kn_rd_q[KB-1:0];

	function automatic logic precedes(
		input logic [KB-1:0] pa, input logic [KB-1:0] sa, input logic [NW-1:0] na,
		input logic [KB-1:0] pb, input logic [KB-1:0] sb, input logic [NW-1:0] nb);
		if (pa != pb)
			return pa < pb;
		if (sa != sb)
			return sa < sb;
		return na < nb;
	endfunction

	logic up_win, r_wins, dn_win;
	assign up_win = precedes(cur_pk_q, cur_sk_q, cur_node_q, kn_pk, kn_sk, oth_node_q);
	assign r_wins = precedes(kn_pk, kn_sk, r_node_q, l_pk_q, l_sk_q, l_node_q);
	assign dn_win = precedes(best_pk_q, best_sk_q, best_node_q, cur_pk_q, cur_sk_q,
		cur_node_q);

	// memories
	always_ff @(posedge clk) begin
		if (hs_we)
			hs_mem[hs_waddr] <= hs_wdata;
		hs_rd_q <= hs_mem[hs_raddr];
	end

	always_ff @(posedge clk) begin
		if (sn_we)
			sn_mem[sn_waddr] <= sn_wdata;
		sn_rd_q <= sn_mem[sn_raddr];
	end

	always_ff @(posedge clk) begin
		if (kn_we)
			kn_mem[node_q] <= {pk_in_q, sk_in_q};
		kn_rd_q <= kn_mem[kn_raddr];
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == NW'(NODE_COUNT - 1)) state_n = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					case (op_t'(operation))
						OP_CLEAR: state_n = ST_DONE;
						OP_POP:   state_n = (count_q == '0) ? ST_DONE : ST_POP0;
						default:  state_n = in_ok ? ST_LOOK1 : ST_DONE;
					endcase
				end
			end
			ST_LOOK1: state_n = ST_LOOK2;
			ST_LOOK2: begin
				if (op_q == OP_PUSH)
					state_n = (present || full) ? ST_DONE : ST_UP0;
				else if (!present || pos_q == last_pos)
					state_n = ST_DONE;
				else
					state_n = ST_LAST0;
			end
			ST_LAST0: state_n = ST_LAST1;
			ST_LAST1: state_n = ST_UP0;
			ST_POP0:  state_n = ST_POP1;
			ST_POP1:  state_n = (cm1 == '0) ? ST_DONE : ST_POP2;
			ST_POP2:  state_n = ST_DN0;
			ST_UP0: begin
				if (pos_q == '0)
					state_n = first_q ? ST_DN0 : ST_FIN;
				else
					state_n = ST_UP1;
			end
			ST_UP1: state_n = ST_UP2;
			ST_UP2: begin
				if (up_win)
					state_n = ST_UP0;
				else
					state_n = first_q ? ST_DN0 : ST_FIN;
			end
			ST_DN0: state_n = left_ok ? ST_DN1 : ST_FIN;
			ST_DN1: state_n = ST_DN2;
			ST_DN2: state_n = right_ok ? ST_DN3 : ST_DN4;
			ST_DN3: state_n = ST_DN4;
			ST_DN4: state_n = dn_win ? ST_DN0 : ST_FIN;
			ST_FIN: state_n = ST_DONE;
			ST_DONE: if (out_load) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		hs_raddr = '0;
		sn_raddr = in_idx;
		kn_raddr = '0;
		hs_we    = 1'b0;
		hs_waddr = pos_q;
		hs_wdata = cur_node_q;
		sn_we    = 1'b0;
		sn_waddr = cur_node_q;
		sn_wdata = pos_q;
		kn_we    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				sn_we    = 1'b1;
				sn_waddr = clr_q;
				sn_wdata = '0;
			end
			ST_LOOK1: hs_raddr = sn_rd_q;
			ST_LOOK2: begin
				hs_raddr = last_pos;
				kn_we    = (op_q == OP_PUSH) && !present && !full;
			end
			ST_LAST0: kn_raddr = hs_rd_q;
			ST_POP0: begin
				kn_raddr = hs_rd_q;
				hs_raddr = last_pos;
			end
			ST_POP1: kn_raddr = hs_rd_q;
			ST_UP0:  hs_raddr = parent;
			ST_UP1:  kn_raddr = hs_rd_q;
			ST_UP2: begin
				// parent moves down into the hole
				hs_we    = up_win;
				hs_wdata = oth_node_q;
				sn_we    = up_win;
				sn_waddr = oth_node_q;
			end
			ST_DN0: hs_raddr = left_w[NW-1:0];
			ST_DN1: begin
				kn_raddr = hs_rd_q;
				hs_raddr = right_w[NW-1:0];
			end
			ST_DN2: kn_raddr = hs_rd_q;
			ST_DN4: begin
				hs_we    = dn_win;
				hs_wdata = best_node_q;
				sn_we    = dn_win;
				sn_waddr = best_node_q;
			end
			ST_FIN: begin
				hs_we = 1'b1;
				sn_we = 1'b1;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			count_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (accept && op_t'(operation) == OP_CLEAR)
				count_q <= '0;
			if (state_q == ST_LOOK2 && op_q == OP_PUSH && !present && !full)
				count_q <= count_q + 1'b1;
			if (state_q == ST_LOOK2 && op_q == OP_REMOVE && present)
				count_q <= cm1;
			if (state_q == ST_POP1)
				count_q <= cm1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q      <= op_t'(operation);
					node_q    <= in_idx;
					pk_in_q   <= pk_ext[KB-1:0];
					sk_in_q   <= sk_ext[KB-1:0];
					pop_hit_q <= 1'b0;
					first_q   <= 1'b0;
					if (op_t'(operation) == OP_POP && count_q == '0)
						stat_q <= STAT_EMPTY;
					else if ((op_t'(operation) == OP_PUSH ||
						op_t'(operation) == OP_REMOVE) && !in_ok)
						stat_q <= STAT_NOT_PRESENT;
					else
						stat_q <= STAT_OK;
				end
			end
			ST_LOOK1: begin
				pos_q      <= sn_rd_q;
				in_range_q <= CW'(sn_rd_q) < count_q;
			end
			ST_LOOK2: begin
				if (op_q == OP_PUSH) begin
					if (present)
						stat_q <= STAT_PRESENT;
					else if (full)
						stat_q <= STAT_FULL;
					cur_node_q <= node_q;
					cur_pk_q   <= pk_in_q;
					cur_sk_q   <= sk_in_q;
					pos_q      <= count_q[NW-1:0];
				end else if (!present) begin
					stat_q <= STAT_NOT_PRESENT;
				end
			end
			ST_LAST0: cur_node_q <= hs_rd_q;
			ST_LAST1: begin
				cur_pk_q <= kn_pk;
				cur_sk_q <= kn_sk;
				first_q  <= 1'b1;
			end
			ST_POP0: top_q <= hs_rd_q;
			ST_POP1: begin
				pop_hit_q  <= 1'b1;
				pop_pk_q   <= kn_pk;
				pop_sk_q   <= kn_sk;
				cur_node_q <= hs_rd_q;
			end
			ST_POP2: begin
				cur_pk_q <= kn_pk;
				cur_sk_q <= kn_sk;
				pos_q    <= '0;
			end
			ST_UP1: oth_node_q <= hs_rd_q;
			ST_UP2: begin
				first_q <= 1'b0;
				if (up_win)
					pos_q <= parent;
			end
			ST_DN1: l_node_q <= hs_rd_q;
			ST_DN2: begin
				l_pk_q      <= kn_pk;
				l_sk_q      <= kn_sk;
				r_node_q    <= hs_rd_q;
				best_node_q <= l_node_q;
				best_pk_q   <= kn_pk;
				best_sk_q   <= kn_sk;
				best_pos_q  <= left_w[NW-1:0];
			end
			ST_DN3: begin
				if (r_wins) begin
					best_node_q <= r_node_q;
					best_pk_q   <= kn_pk;
					best_sk_q   <= kn_sk;
					best_pos_q  <= right_w[NW-1:0];
				end
			end
			ST_DN4: if (dn_win) pos_q <= best_pos_q;
			default: ;
		endcase
	end

	// result register
	logic [NW+11:0] top_ext;
	logic [KB+31:0] ppk_ext, psk_ext;
	logic [CW+12:0] cnt_ext;

	assign top_ext = {12'd0, top_q};
	assign ppk_ext = {32'd0, pop_pk_q};
	assign psk_ext = {32'd0, pop_sk_q};
	assign cnt_ext = {13'd0, count_q};

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q           <= stat_q;
			popped_node_q      <= pop_hit_q ? top_ext[11:0] : 12'd0;
			popped_primary_q   <= pop_hit_q ? ppk_ext[31:0] : 32'd0;
			popped_secondary_q <= pop_hit_q ? psk_ext[31:0] : 32'd0;
			entries_q          <= cnt_ext[12:0];
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign popped_node      = popped_node_q;
	assign popped_primary   = popped_primary_q;
	assign popped_secondary = popped_secondary_q;
	assign entries          = entries_q;

	// checks
	`IMHQ_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(NODE_COUNT), "count overflow")
	`IMHQ_ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "input not stalled while busy")
	`IMHQ_ASSERT_NEXT(a_done_holds, state_q == ST_DONE && out_valid_q && out_stall,
		state_q == ST_DONE, "result overwrote a stalled transfer")
	`IMHQ_ASSERT_NOW(a_empty_zero, out_valid && status == STAT_EMPTY, entries == 13'd0,
		"empty status with entries")

endmodule

`default_nettype wire

// ----- test/indexed_min_heap_queue_checker.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_checker
// Watches both channels, keeps its own heap to predict each result and
// compares every output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_queue_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [11:0] node,
	input  wire logic [31:0] primary_key,
	input  wire logic [31:0] secondary_key,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [2:0]  status,
	input  wire logic [11:0] popped_node,
	input  wire logic [31:0] popped_primary,
	input  wire logic [31:0] popped_secondary,
	input  wire logic [12:0] entries,
	output int               fail_count,
	output int               pending
);
	import imhq_pkg::*;

	localparam int NODES = NODE_COUNT_DEF;

	typedef struct packed {
		status_t     st;
		logic [11:0] pnode;
		logic [31:0] pprim;
		logic [31:0] psec;
		logic [12:0] count;
	} answer_t;

	answer_t     answers[$];
	int          slot_node[NODES];
	int          node_slot[NODES];
	bit          held[NODES];
	logic [31:0] prim_of[NODES];
	logic [31:0] sec_of[NODES];
	int          fill;

	function automatic bit ahead(int a, int b);
		if (prim_of[a] != prim_of[b]) return prim_of[a] < prim_of[b];
		if (sec_of[a] != sec_of[b]) return sec_of[a] < sec_of[b];
		return a < b;
	endfunction

	function automatic void put(int pos, int nd);
		slot_node[pos] = nd;
		node_slot[nd] = pos;
	endfunction

	function automatic void bubble_up(int pos);
		int par, here, above;
		while (pos > 0) begin
			par = (pos - 1) / 2;
			here = slot_node[pos];
			above = slot_node[par];
			if (!ahead(here, above)) break;
			put(pos, above);
			put(par, here);
			pos = par;
		end
	endfunction

	function automatic void bubble_down(int pos);
		int lft, child, here, below;
		forever begin
			lft = pos * 2 + 1;
			if (lft >= fill) break;
			child = lft;
			if (lft + 1 < fill && ahead(slot_node[lft + 1], slot_node[lft])) child = lft + 1;
			here = slot_node[pos];
			below = slot_node[child];
			if (!ahead(below, here)) break;
			put(pos, below);
			put(child, here);
			pos = child;
		end
	endfunction

	function automatic answer_t heap_op(op_t op, int nd, logic [31:0] pk, logic [31:0] sk);
		answer_t a;
		int top, pos;
		a = '0;
		a.st = STAT_OK;
		case (op)
			OP_PUSH: begin
				if (held[nd]) a.st = STAT_PRESENT;
				else if (fill >= NODES) a.st = STAT_FULL;
				else begin
					prim_of[nd] = pk;
					sec_of[nd] = sk;
					held[nd] = 1;
					put(fill, nd);
					fill++;
					bubble_up(fill - 1);
				end
			end
			OP_POP: begin
				if (fill == 0) a.st = STAT_EMPTY;
				else begin
					top = slot_node[0];
					a.pnode = 12'(top);
					a.pprim = prim_of[top];
					a.psec = sec_of[top];
					held[top] = 0;
					fill--;
					if (fill > 0) begin
						put(0, slot_node[fill]);
						bubble_down(0);
					end
				end
			end
			OP_REMOVE: begin
				if (!held[nd]) a.st = STAT_NOT_PRESENT;
				else begin
					pos = node_slot[nd];
					held[nd] = 0;
					fill--;
					if (pos < fill) begin
						put(pos, slot_node[fill]);
						if (pos > 0 && ahead(slot_node[pos], slot_node[(pos - 1) / 2]))
							bubble_up(pos);
						else
							bubble_down(pos);
					end
				end
			end
			default: begin
				foreach (held[i]) held[i] = 0;
				fill = 0;
			end
		endcase
		a.count = 13'(fill);
		return a;
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
		fill = 0;
		foreach (held[i]) held[i] = 0;
	end

	always @(posedge clk) begin
		answer_t want, got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				answers.push_back(heap_op(op_t'(operation), int'(node), primary_key,
					secondary_key));
			if (out_valid && !out_stall) begin
				got = {status_t'(status), popped_node, popped_primary, popped_secondary, entries};
				if (answers.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected output transfer: %p", got);
				end else begin
					want = answers.pop_front();
					if (got != want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p, got %p", want, got);
					end
				end
			end
			pending = answers.size();
		end
	end

endmodule

`default_nettype wire

// ----- test/indexed_min_heap_queue_test.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_test
// Drives directed and random heap operations with random idle gaps and
// receiver stalls, including a long output hold-off; the checker predicts.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_queue_test;
	import imhq_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  operation = '0;
	logic [11:0] node = '0;
	logic [31:0] primary_key = '0;
	logic [31:0] secondary_key = '0;
	logic        out_valid;
	logic        out_stall = 1;
	logic [2:0]  status;
	logic [11:0] popped_node;
	logic [31:0] popped_primary;
	logic [31:0] popped_secondary;
	logic [12:0] entries;
	int          fail_count, pending;
	bit          calm = 0;
	bit          hold_off = 0;
	int          sent = 0;

	always #2 clk = ~clk;

	indexed_min_heap_queue i_dut (.*);

	indexed_min_heap_queue_checker i_checker (.*);

	// receiver: random stalls, one long hold-off early on
	always @(posedge clk) begin
		if (!arst_n) out_stall <= 1;
		else if (hold_off) out_stall <= 1;
		else out_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);
	end

	initial begin
		@(posedge clk);
		wait (sent >= 30);
		@(posedge clk);
		hold_off = 1;
		repeat (400) @(posedge clk);
		hold_off = 0;
	end

	// one transfer; random idle cycles before it
	task automatic offer(op_t op, logic [11:0] nd, logic [31:0] pk, logic [31:0] sk);
		while (!calm && $urandom_range(99) < 33) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		operation <= op;
		node <= nd;
		primary_key <= pk;
		secondary_key <= sk;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	task automatic random_op(int span);
		int r;
		r = $urandom_range(99);
		if (r < 50)
			offer(OP_PUSH, 12'($urandom_range(span)),
				$urandom_range(7) == 0 ? $urandom : $urandom_range(15),
				$urandom_range(3) == 0 ? $urandom : $urandom_range(3));
		else if (r < 80) offer(OP_POP, 12'($urandom), $urandom, $urandom);
		else if (r < 97) offer(OP_REMOVE, 12'($urandom_range(span)), $urandom, $urandom);
		else offer(OP_CLEAR, 12'($urandom), $urandom, $urandom);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		offer(OP_POP, 0, 0, 0);
		offer(OP_REMOVE, 12'hFFF, 0, 0);
		offer(OP_PUSH, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer(OP_PUSH, 12'hFFF, 0, 0);
		offer(OP_PUSH, 0, 0, 0);
		offer(OP_PUSH, 5, 32'h0001_0000, 32'h0000_0002);
		offer(OP_PUSH, 6, 32'h0001_0000, 32'h0000_0001);
		offer(OP_PUSH, 4, 32'h0001_0000, 32'h0000_0001);
		offer(OP_PUSH, 7, 32'hAAAA_5555, 32'h5555_AAAA);
		offer(OP_REMOVE, 0, 0, 0);
		offer(OP_REMOVE, 0, 0, 0);
		repeat (5) offer(OP_POP, 0, 0, 0);
		offer(OP_PUSH, 9, 1, 1);
		offer(OP_CLEAR, 0, 0, 0);
		offer(OP_POP, 0, 0, 0);
		offer(OP_PUSH, 9, 2, 2);
		offer(OP_REMOVE, 9, 0, 0);
		for (int i = 0; i < 600; i++) begin
			if (i == 250) calm = 1;
			if (i == 350) calm = 0;
			random_op(i < 450 ? 63 : 4095);
		end
		in_valid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+design
design/imhq_pkg.sv
design/indexed_min_heap_queue.sv
test/indexed_min_heap_queue_checker.sv
test/indexed_min_heap_queue_test.sv
